// ===== hw/rtl/per_host_flow_direction_counter_macros.svh =====
// Assertion macros for the port-level checker of the per-host flow counter.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef PER_HOST_FLOW_DIRECTION_COUNTER_MACROS_SVH
`define PER_HOST_FLOW_DIRECTION_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PHFDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PHFDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/phfdc_pkg.sv =====
// Shared types and constants for the per-host flow direction counter.
// No dependencies; used by the controller, the datapath and the top level.
package phfdc_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int WORD_W            = 32;
    localparam int SLOT_W            = 8;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC_SCAN,
        ST_SRC_UPD,
        ST_DST_SCAN,
        ST_DST_UPD,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] bidir;
        logic [WORD_W-1:0] one_out;
        logic [WORD_W-1:0] one_in;
    } entry_t;

    typedef struct packed {
        logic accept;      // latch the input word
        logic scan_init;   // restart scan pointer
        logic scan_run;    // step the table scan
        logic dst_pass;    // work on destination address
        logic upd;         // write back / insert the found entry
        logic rd_issue;    // read the requested slot
        logic rd_capture;  // load read result
        logic rec_finish;  // load record result
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;   // hit or miss resolved
    } ctrl_sts_t;

    function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
        sat_inc = (&v) ? v : v + WORD_W'(1);
    endfunction

endpackage

// ===== hw/rtl/phfdc_ctrl.sv =====
// Sequencing FSM for the per-host flow direction counter.
// Depends on phfdc_pkg; drives phfdc_datapath through ctrl_cmd_t.
module phfdc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 opcode,
    input  phfdc_pkg::ctrl_sts_t sts,
    output phfdc_pkg::ctrl_cmd_t cmd,
    output logic                 busy,
    output logic                 done
);

    phfdc_pkg::state_t state_reg, state_next;
    logic              done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phfdc_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            phfdc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (opcode == phfdc_pkg::OP_READ)
                    begin
                        state_next = phfdc_pkg::ST_RD_ISSUE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = phfdc_pkg::ST_SRC_SCAN;
                    end
                end
            end
            phfdc_pkg::ST_SRC_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = phfdc_pkg::ST_SRC_UPD;
                end
            end
            phfdc_pkg::ST_SRC_UPD:
            begin
                cmd.upd       = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = phfdc_pkg::ST_DST_SCAN;
            end
            phfdc_pkg::ST_DST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.dst_pass = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = phfdc_pkg::ST_DST_UPD;
                end
            end
            phfdc_pkg::ST_DST_UPD:
            begin
                cmd.upd        = 1'b1;
                cmd.dst_pass   = 1'b1;
                cmd.rec_finish = 1'b1;
                done_next      = 1'b1;
                state_next     = phfdc_pkg::ST_IDLE;
            end
            phfdc_pkg::ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = phfdc_pkg::ST_RD_DATA;
            end
            phfdc_pkg::ST_RD_DATA:
            begin
                cmd.rd_capture = 1'b1;
                done_next      = 1'b1;
                state_next     = phfdc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = phfdc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != phfdc_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

// ===== hw/rtl/phfdc_datapath.sv =====
// Host table memory, scan pointer, update path and result registers.
// Depends on phfdc_pkg; commanded by phfdc_ctrl.
module phfdc_datapath #(
    parameter int TABLE_ENTRIES = phfdc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  phfdc_pkg::ctrl_cmd_t           cmd,
    output phfdc_pkg::ctrl_sts_t           sts,
    input  logic [phfdc_pkg::WORD_W-1:0]   source_addr,
    input  logic [phfdc_pkg::WORD_W-1:0]   dest_addr,
    input  logic [phfdc_pkg::WORD_W-1:0]   reverse_packets,
    input  logic [phfdc_pkg::SLOT_W-1:0]   slot_index,
    output logic                           status,
    output logic                           entry_valid,
    output logic [phfdc_pkg::WORD_W-1:0]   entry_addr,
    output logic [phfdc_pkg::WORD_W-1:0]   bidir_count,
    output logic [phfdc_pkg::WORD_W-1:0]   one_way_out_count,
    output logic [phfdc_pkg::WORD_W-1:0]   one_way_in_count
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > phfdc_pkg::SLOT_W) ? CNT_W : phfdc_pkg::SLOT_W;

    phfdc_pkg::entry_t mem [TABLE_ENTRIES];

    // latched input word
    logic [phfdc_pkg::WORD_W-1:0] src_reg, dst_reg;
    logic                         bidir_reg;
    logic [phfdc_pkg::SLOT_W-1:0] slot_reg;

    // scan and fill control
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    phfdc_pkg::entry_t rd_data_reg;

    // pending update
    logic [IDX_W-1:0]  upd_idx_reg;
    phfdc_pkg::entry_t upd_entry_reg;
    logic              upd_drop_reg, upd_ins_reg;
    logic              status_acc_reg;
    logic              rd_ok_reg;

    // result registers
    logic                         status_reg, valid_reg;
    logic [phfdc_pkg::WORD_W-1:0] addr_reg, bidir_cnt_reg, out_cnt_reg, in_cnt_reg;

    logic [phfdc_pkg::WORD_W-1:0] key;
    logic                         hit, miss, issue, rd_en, wr_en;
    logic [IDX_W-1:0]             rd_addr;
    phfdc_pkg::entry_t            wr_entry, new_entry;

    assign key   = cmd.dst_pass ? dst_reg : src_reg;
    assign hit   = pend_reg && (rd_data_reg.key == key);
    assign miss  = !pend_reg && (scan_idx_reg == fill_reg);
    assign issue = cmd.scan_run && !hit && (scan_idx_reg != fill_reg);
    assign sts.scan_done = cmd.scan_run && (hit || miss);

    assign scan_idx_next = cmd.scan_init ? '0 : scan_idx_reg + CNT_W'(issue);
    assign pend_next     = cmd.scan_init ? 1'b0 : (cmd.scan_run ? issue : pend_reg);
    assign fill_next     = fill_reg + CNT_W'(cmd.upd && upd_ins_reg && !upd_drop_reg);

    assign rd_en   = issue || cmd.rd_issue;
    assign rd_addr = cmd.rd_issue ? IDX_W'(slot_reg) : scan_idx_reg[IDX_W-1:0];
    assign wr_en   = cmd.upd && !upd_drop_reg;

    always_comb
    begin
        new_entry         = '0;
        new_entry.key     = key;
        wr_entry          = upd_entry_reg;
        if (bidir_reg)
        begin
            wr_entry.bidir = phfdc_pkg::sat_inc(upd_entry_reg.bidir);
        end
        else if (cmd.dst_pass)
        begin
            wr_entry.one_in = phfdc_pkg::sat_inc(upd_entry_reg.one_in);
        end
        else
        begin
            wr_entry.one_out = phfdc_pkg::sat_inc(upd_entry_reg.one_out);
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[upd_idx_reg] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            src_reg        <= source_addr;
            dst_reg        <= dest_addr;
            bidir_reg      <= (reverse_packets != '0);
            slot_reg       <= slot_index;
            status_acc_reg <= 1'b0;
        end
        if (cmd.scan_run)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (sts.scan_done)
        begin
            upd_idx_reg   <= hit ? cmp_idx_reg : fill_reg[IDX_W-1:0];
            upd_entry_reg <= hit ? rd_data_reg : new_entry;
            upd_ins_reg   <= !hit;
            upd_drop_reg  <= !hit && (fill_reg == CNT_W'(TABLE_ENTRIES));
        end
        if (cmd.upd)
        begin
            status_acc_reg <= status_acc_reg | upd_drop_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= (CMP_W'(slot_reg) < CMP_W'(fill_reg));
        end
        if (cmd.rec_finish)
        begin
            status_reg    <= status_acc_reg | upd_drop_reg;
            valid_reg     <= 1'b0;
            addr_reg      <= '0;
            bidir_cnt_reg <= '0;
            out_cnt_reg   <= '0;
            in_cnt_reg    <= '0;
        end
        else if (cmd.rd_capture)
        begin
            status_reg    <= 1'b0;
            valid_reg     <= rd_ok_reg;
            addr_reg      <= rd_ok_reg ? rd_data_reg.key     : '0;
            bidir_cnt_reg <= rd_ok_reg ? rd_data_reg.bidir   : '0;
            out_cnt_reg   <= rd_ok_reg ? rd_data_reg.one_out : '0;
            in_cnt_reg    <= rd_ok_reg ? rd_data_reg.one_in  : '0;
        end
    end

    assign status            = status_reg;
    assign entry_valid       = valid_reg;
    assign entry_addr        = addr_reg;
    assign bidir_count       = bidir_cnt_reg;
    assign one_way_out_count = out_cnt_reg;
    assign one_way_in_count  = in_cnt_reg;

endmodule

// ===== hw/rtl/per_host_flow_direction_counter.sv =====
// Top level of the per-host flow direction counter.
// Depends on phfdc_pkg, phfdc_ctrl and phfdc_datapath.
//
// Usage:
//   A word is taken when start is high and busy is low. opcode 0 records a
//   flow (source_addr, dest_addr, reverse_packets); opcode 1 reads the slot
//   given by slot_index. Exactly one result word follows, shown for a
//   single cycle with done high; the receiver must take it then, there is
//   no backpressure on the result side.
// Operation:
//   Read: the slot is read in ST_RD_ISSUE, captured in ST_RD_DATA, then done.
//   Record: each address is looked up by a linear scan of the filled slots,
//   one memory read per cycle, until a hit or until every filled slot has
//   been read; a write-back step follows, source first, then destination.
//   One word is in flight at a time; busy stays high until the result
//   cycle, when a new word may be taken.
// Reset:
//   The fill count returns to zero, which empties the table at once; slots
//   are handed out in order and a new slot's counters are written as zero.
//   No clearing pass is needed. A full table drops new hosts and sets status.
module per_host_flow_direction_counter #(
    parameter int TABLE_ENTRIES = phfdc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic                           opcode,
    input  logic [phfdc_pkg::WORD_W-1:0]   source_addr,
    input  logic [phfdc_pkg::WORD_W-1:0]   dest_addr,
    input  logic [phfdc_pkg::WORD_W-1:0]   reverse_packets,
    input  logic [phfdc_pkg::SLOT_W-1:0]   slot_index,
    output logic                           status,
    output logic                           entry_valid,
    output logic [phfdc_pkg::WORD_W-1:0]   entry_addr,
    output logic [phfdc_pkg::WORD_W-1:0]   bidir_count,
    output logic [phfdc_pkg::WORD_W-1:0]   one_way_out_count,
    output logic [phfdc_pkg::WORD_W-1:0]   one_way_in_count
);

    // Controller/datapath handshake
    phfdc_pkg::ctrl_cmd_t cmd;
    phfdc_pkg::ctrl_sts_t sts;

    // FSM: sequences source scan, source update, destination scan,
    // destination update, or the two-step slot read.
    phfdc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Table memory, scan pointer, saturating update and result registers.
    phfdc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .source_addr       (source_addr),
        .dest_addr         (dest_addr),
        .reverse_packets   (reverse_packets),
        .slot_index        (slot_index),
        .status            (status),
        .entry_valid       (entry_valid),
        .entry_addr        (entry_addr),
        .bidir_count       (bidir_count),
        .one_way_out_count (one_way_out_count),
        .one_way_in_count  (one_way_in_count)
    );

endmodule

// ===== hw/rtl/phfdc_checker.sv =====
// Port-level checker for the per-host flow direction counter, bound to the top.
// Depends on phfdc_pkg and per_host_flow_direction_counter_macros.svh.
`include "per_host_flow_direction_counter_macros.svh"

module phfdc_props (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic                           status,
    input logic                           entry_valid,
    input logic [phfdc_pkg::WORD_W-1:0]   entry_addr,
    input logic [phfdc_pkg::WORD_W-1:0]   bidir_count,
    input logic [phfdc_pkg::WORD_W-1:0]   one_way_out_count,
    input logic [phfdc_pkg::WORD_W-1:0]   one_way_in_count
);

    logic no_entry;
    logic no_counts;

    assign no_entry  = !entry_valid && (entry_addr == '0);
    assign no_counts = (bidir_count == '0) && (one_way_out_count == '0)
                       && (one_way_in_count == '0);

    `PHFDC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `PHFDC_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
    `PHFDC_ASSERT_NXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `PHFDC_ASSERT_NOW(a_status_rec, done && status, no_entry, "status on an entry word")
    `PHFDC_ASSERT_NOW(a_empty_zero, done && !entry_valid, no_counts, "counts without an entry")

endmodule

bind per_host_flow_direction_counter phfdc_props u_phfdc_props (.*);

// ===== verif/phfdc_checker.sv =====
// Result checker for the per-host flow direction counter: predicts each result
// word from the accepted input words and compares it field by field.
// Depends on phfdc_pkg for widths and opcodes.
module phfdc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           done,
    input  logic                           opcode,
    input  logic [phfdc_pkg::WORD_W-1:0]   source_addr,
    input  logic [phfdc_pkg::WORD_W-1:0]   dest_addr,
    input  logic [phfdc_pkg::WORD_W-1:0]   reverse_packets,
    input  logic [phfdc_pkg::SLOT_W-1:0]   slot_index,
    input  logic                           status,
    input  logic                           entry_valid,
    input  logic [phfdc_pkg::WORD_W-1:0]   entry_addr,
    input  logic [phfdc_pkg::WORD_W-1:0]   bidir_count,
    input  logic [phfdc_pkg::WORD_W-1:0]   one_way_out_count,
    input  logic [phfdc_pkg::WORD_W-1:0]   one_way_in_count,
    output int                             fail_count,
    output int                             pending
);

    localparam int W         = phfdc_pkg::WORD_W;
    localparam int TBL_DEPTH = phfdc_pkg::TABLE_ENTRIES_DEF;

    typedef struct packed {
        logic         status;
        logic         entry_valid;
        logic [W-1:0] addr;
        logic [W-1:0] bidir;
        logic [W-1:0] out_cnt;
        logic [W-1:0] in_cnt;
    } host_report_t;

    // shadow host table; slots below hosts_filled are in use
    logic [W-1:0] host_addr [TBL_DEPTH];
    logic [W-1:0] cnt_bidir [TBL_DEPTH];
    logic [W-1:0] cnt_out   [TBL_DEPTH];
    logic [W-1:0] cnt_in    [TBL_DEPTH];
    int           hosts_filled = 0;

    host_report_t awaited_reports[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [W-1:0] bump(input logic [W-1:0] cnt);
        return (cnt == '1) ? cnt : cnt + 1'b1;
    endfunction

    // slot of addr, new slot with cleared counters if unknown, -1 when full
    function automatic int claim_slot(input logic [W-1:0] addr);
        int i;
        for (i = 0; i < hosts_filled; i++)
        begin
            if (host_addr[i] == addr)
                return i;
        end
        if (hosts_filled >= TBL_DEPTH)
            return -1;
        host_addr[hosts_filled] = addr;
        cnt_bidir[hosts_filled] = '0;
        cnt_out[hosts_filled]   = '0;
        cnt_in[hosts_filled]    = '0;
        hosts_filled++;
        return hosts_filled - 1;
    endfunction

    function automatic host_report_t apply_word(input logic op,
                                                input logic [W-1:0] src,
                                                input logic [W-1:0] dst,
                                                input logic [W-1:0] rev,
                                                input logic [phfdc_pkg::SLOT_W-1:0] idx);
        host_report_t rpt;
        int           slot;
        logic         two_way;
        rpt     = '0;
        two_way = (rev != '0);
        if (op == phfdc_pkg::OP_RECORD)
        begin
            slot = claim_slot(src);
            if (slot < 0)
                rpt.status = 1'b1;
            else if (two_way)
                cnt_bidir[slot] = bump(cnt_bidir[slot]);
            else
                cnt_out[slot] = bump(cnt_out[slot]);
            slot = claim_slot(dst);
            if (slot < 0)
                rpt.status = 1'b1;
            else if (two_way)
                cnt_bidir[slot] = bump(cnt_bidir[slot]);
            else
                cnt_in[slot] = bump(cnt_in[slot]);
        end
        else if (int'(idx) < hosts_filled)
        begin
            rpt.entry_valid = 1'b1;
            rpt.addr        = host_addr[idx];
            rpt.bidir       = cnt_bidir[idx];
            rpt.out_cnt     = cnt_out[idx];
            rpt.in_cnt      = cnt_in[idx];
        end
        return rpt;
    endfunction

    task automatic check_field(input string name, input logic [W-1:0] want,
                               input logic [W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // result first: a new word may be taken in the same cycle as a result
    always @(posedge clk)
    begin
        host_report_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("result word with no word outstanding");
                    fail_count++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("status", W'(want.status), W'(status));
                    check_field("entry_valid", W'(want.entry_valid), W'(entry_valid));
                    check_field("entry_addr", want.addr, entry_addr);
                    check_field("bidir_count", want.bidir, bidir_count);
                    check_field("one_way_out_count", want.out_cnt, one_way_out_count);
                    check_field("one_way_in_count", want.in_cnt, one_way_in_count);
                end
            end
            if (start && !busy)
                awaited_reports.push_back(apply_word(opcode, source_addr, dest_addr,
                                                     reverse_packets, slot_index));
            pending = awaited_reports.size();
        end
    end

endmodule

// ===== verif/tb_per_host_flow_direction_counter.sv =====
// Top of the per-host flow direction counter testbench: clock, reset, stimulus
// and verdict. Depends on phfdc_pkg, the block itself and phfdc_checker.
module tb_per_host_flow_direction_counter;

    localparam int W           = phfdc_pkg::WORD_W;
    localparam int SW          = phfdc_pkg::SLOT_W;
    localparam int TBL_DEPTH   = phfdc_pkg::TABLE_ENTRIES_DEF;
    localparam int RANDOM_WORDS = 600;
    // slowest run: ~750 words, each two full-table scans plus the longest gap, with margin
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 20;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic          done;
    logic          opcode;
    logic [W-1:0]  source_addr;
    logic [W-1:0]  dest_addr;
    logic [W-1:0]  reverse_packets;
    logic [SW-1:0] slot_index;
    logic          status;
    logic          entry_valid;
    logic [W-1:0]  entry_addr;
    logic [W-1:0]  bidir_count;
    logic [W-1:0]  one_way_out_count;
    logic [W-1:0]  one_way_in_count;

    int            fail_count;
    int            pending;
    int            cycle_count;

    // Stimulus-side view of which hosts the table holds. It only steers address
    // choice and keeps reads inside written slots; the checker does the predicting.
    logic [W-1:0]  host_pool[$];
    logic          burst_mode;

    per_host_flow_direction_counter i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .done              (done),
        .opcode            (opcode),
        .source_addr       (source_addr),
        .dest_addr         (dest_addr),
        .reverse_packets   (reverse_packets),
        .slot_index        (slot_index),
        .status            (status),
        .entry_valid       (entry_valid),
        .entry_addr        (entry_addr),
        .bidir_count       (bidir_count),
        .one_way_out_count (one_way_out_count),
        .one_way_in_count  (one_way_in_count)
    );

    phfdc_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .done              (done),
        .opcode            (opcode),
        .source_addr       (source_addr),
        .dest_addr         (dest_addr),
        .reverse_packets   (reverse_packets),
        .slot_index        (slot_index),
        .status            (status),
        .entry_valid       (entry_valid),
        .entry_addr        (entry_addr),
        .bidir_count       (bidir_count),
        .one_way_out_count (one_way_out_count),
        .one_way_in_count  (one_way_in_count),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("cycle limit of %0d reached", CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic is_known(input logic [W-1:0] addr);
        foreach (host_pool[i])
        begin
            if (host_pool[i] == addr)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [W-1:0] fresh_host();
        logic [W-1:0] addr;
        do
            addr = $urandom;
        while (is_known(addr));
        return addr;
    endfunction

    // Fresh hosts are half the picks while the table fills; once full they are rarer
    // and each one exercises the dropped-address path.
    function automatic logic [W-1:0] pick_host();
        int fresh_pct;
        fresh_pct = (host_pool.size() < TBL_DEPTH) ? 50 : 20;
        if (host_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct)
            return fresh_host();
        return host_pool[$urandom_range(0, host_pool.size() - 1)];
    endfunction

    // Half one-way flows, the rest bidirectional with edge and random counts.
    function automatic logic [W-1:0] pick_reverse();
        case ($urandom_range(0, 5))
            3:       return 32'h0000_0001;
            4:       return 32'hFFFF_FFFF;
            5:       return $urandom;
            default: return '0;
        endcase
    endfunction

    // Mostly short gaps, a few long ones; none at all in burst stretches.
    function automatic int pick_gap();
        int roll;
        if (burst_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(0, 2);
        if (roll < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 80);
    endfunction

    // Present one word at the falling edge and hold it until the block takes it.
    // Start stays high between back-to-back words; it is touched once per edge.
    task automatic send_word(input logic op, input logic [W-1:0] src,
                             input logic [W-1:0] dst, input logic [W-1:0] rev,
                             input logic [SW-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start           = 1'b1;
        opcode          = op;
        source_addr     = src;
        dest_addr       = dst;
        reverse_packets = rev;
        slot_index      = idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Record word; slot_index is a don't-care here and carries noise.
    task automatic record_flow(input logic [W-1:0] src, input logic [W-1:0] dst,
                               input logic [W-1:0] rev);
        if (!is_known(src) && host_pool.size() < TBL_DEPTH)
            host_pool.push_back(src);
        if (!is_known(dst) && host_pool.size() < TBL_DEPTH)
            host_pool.push_back(dst);
        send_word(phfdc_pkg::OP_RECORD, src, dst, rev, SW'($urandom));
    endtask

    // Read word; address fields are don't-cares and carry noise.
    task automatic read_slot(input logic [SW-1:0] idx);
        send_word(phfdc_pkg::OP_READ, $urandom, $urandom, $urandom, idx);
    endtask

    initial
    begin
        logic [W-1:0] src;
        rst_n           = 1'b0;
        start           = 1'b0;
        opcode          = phfdc_pkg::OP_RECORD;
        source_addr     = '0;
        dest_addr       = '0;
        reverse_packets = '0;
        slot_index      = '0;
        burst_mode      = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed words ---
        // extreme addresses, one-way then bidirectional with max reverse count
        record_flow(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        record_flow(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        // source equals destination: bidir twice, then out and in once each
        record_flow(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h0000_0001);
        record_flow(32'h5555_5555, 32'h5555_5555, 32'h0000_0000);
        // known hosts only, top bit of the reverse count alone
        record_flow(32'h0000_0000, 32'h5555_5555, 32'h8000_0000);
        record_flow(32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0000);
        // one known host with one new host
        record_flow(32'h0000_0000, 32'h1234_5678, 32'h0000_0000);
        for (int i = 0; i < 5; i++)
            read_slot(SW'(i));
        send_word(phfdc_pkg::OP_READ, '1, '1, '1, SW'(0));

        // --- random words: fill the table, then run it full ---
        burst_mode = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) != 0)
            begin
                src = pick_host();
                if ($urandom_range(0, 9) == 0)
                    record_flow(src, src, pick_reverse());
                else
                    record_flow(src, pick_host(), pick_reverse());
            end
            else
            begin
                read_slot(SW'($urandom_range(0, host_pool.size() - 1)));
            end
        end

        // make sure the table is full before the closing cases
        while (host_pool.size() < TBL_DEPTH)
            record_flow(fresh_host(), fresh_host(), pick_reverse());

        // --- directed words on a full table ---
        read_slot(SW'(TBL_DEPTH - 1));
        read_slot(SW'(0));
        record_flow(fresh_host(), fresh_host(), 32'h0000_0000);  // both dropped
        record_flow(host_pool[0], fresh_host(), 32'h0000_0005);  // source still counts
        record_flow(fresh_host(), host_pool[TBL_DEPTH - 1], 32'h0000_0000);
        record_flow(host_pool[3], host_pool[3], 32'h0000_0000);
        read_slot(SW'(0));
        read_slot(SW'(3));
        read_slot(SW'(TBL_DEPTH - 1));

        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
